// ===== rtl/byc_pkg.sv =====
// ----------------------------------------------------------------------------
// byc_pkg
// shared widths, colour matrix coefficients, register indexes and types
// ----------------------------------------------------------------------------
package byc_pkg;

    localparam int COMP_W      = 8;
    localparam int FRAC_W      = 16;
    localparam int COEF_W      = 16;
    localparam int PROD_W      = COMP_W + COEF_W;
    localparam int ACC_W       = PROD_W + 2;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 8;
    localparam int IN_TDATA_W  = 4 * COMP_W;
    localparam int OUT_TDATA_W = 6 * COMP_W;

    // q0.16 magnitudes
    localparam logic [COEF_W-1:0] C_Y_R = 16'd19595;
    localparam logic [COEF_W-1:0] C_Y_G = 16'd38470;
    localparam logic [COEF_W-1:0] C_Y_B = 16'd7471;
    localparam logic [COEF_W-1:0] C_U_R = 16'd11076;
    localparam logic [COEF_W-1:0] C_U_G = 16'd21692;
    localparam logic [COEF_W-1:0] C_U_B = 16'd32768;
    localparam logic [COEF_W-1:0] C_V_R = 16'd32768;
    localparam logic [COEF_W-1:0] C_V_G = 16'd27460;
    localparam logic [COEF_W-1:0] C_V_B = 16'd5308;

    localparam logic signed [ACC_W-1:0] C_OFFSET = ACC_W'(128 * 65536);

    localparam logic [CFG_INDEX_W-1:0] CFG_CHROMA_MODE  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA_ENABLE = CFG_INDEX_W'(1);

    typedef struct packed {
        logic [COMP_W-1:0] alpha;
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
        logic              line_start;
    } t_bgra;

    typedef struct packed {
        logic [COMP_W-1:0] y;
        logic [COMP_W-1:0] u;
        logic [COMP_W-1:0] v;
        logic [COMP_W-1:0] alpha;
        logic              line_start;
    } t_yuv;

    typedef struct packed {
        logic chroma_mode;
        logic alpha_enable;
    } t_cfg;

endpackage

// ===== rtl/bgra_to_yuv_converter.sv =====
// an accepted pixel passes the input register, the colour matrix register and
// the pairing output register; in 4:2:2 the result follows the odd pixel of a pair
// throughput: one pixel per cycle when the output is not stalled, set by the
// three-register pipeline (input, colour matrix and pairing output registers)
// reset: synchronous active low; clears valids, pair phase and both config registers
// ----------------------------------------------------------------------------
// bgra_to_yuv_converter
// bgra pixel stream to full-range y/u/v, 4:4:4 or pair-averaged 4:2:2
// ----------------------------------------------------------------------------
module bgra_to_yuv_converter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [byc_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [byc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // blue, green, red, alpha_in
    input  logic [byc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // line_start
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // luma_first, luma_second, chroma_u, chroma_v, alpha_first, alpha_second
    output logic [byc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import byc_pkg::*;

    t_cfg  r_cfg;
    t_bgra in_pix;
    t_yuv  csc_pix;
    logic  csc_valid;
    logic  pair_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CHROMA_MODE: begin
                    r_cfg.chroma_mode <= i_cfg_data[0];
                end
                CFG_ALPHA_ENABLE: begin
                    r_cfg.alpha_enable <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        in_pix.blue       = s_axis_tdata[COMP_W-1:0];
        in_pix.green      = s_axis_tdata[2*COMP_W-1:COMP_W];
        in_pix.red        = s_axis_tdata[3*COMP_W-1:2*COMP_W];
        in_pix.alpha      = s_axis_tdata[4*COMP_W-1:3*COMP_W];
        in_pix.line_start = s_axis_tuser;
    end

    byc_csc u_csc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_pix   (in_pix),
        .o_valid (csc_valid),
        .i_ready (pair_ready),
        .o_pix   (csc_pix)
    );

    byc_pair u_pair (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (csc_valid),
        .o_ready (pair_ready),
        .i_pix   (csc_pix),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

endmodule

// ===== rtl/byc_csc.sv =====
// ----------------------------------------------------------------------------
// byc_csc
// input register, colour matrix with floor and clamp, result register
// ----------------------------------------------------------------------------
module byc_csc (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  byc_pkg::t_bgra i_pix,
    output logic           o_valid,
    input  logic           i_ready,
    output byc_pkg::t_yuv  o_pix
);
    import byc_pkg::*;

    logic              r_in_valid;
    t_bgra             r_in;
    logic              r_out_valid;
    t_yuv              r_out;
    logic              s2_ready;
    logic [PROD_W-1:0] p_yr, p_yg, p_yb, p_ur, p_ug, p_ub, p_vr, p_vg, p_vb;
    logic signed [ACC_W-1:0] y_acc, u_acc, v_acc;
    t_yuv              n_out;

    function automatic logic [COMP_W-1:0] sat_q16(input logic signed [ACC_W-1:0] acc);
        logic [COMP_W-1:0] res;
        if (acc[ACC_W-1]) begin
            res = '0;
        end else if (|acc[ACC_W-2:FRAC_W+COMP_W]) begin
            res = '1;
        end else begin
            res = acc[FRAC_W+COMP_W-1:FRAC_W];
        end
        return res;
    endfunction

    assign s2_ready = !r_out_valid || i_ready;
    assign o_ready  = !r_in_valid || s2_ready;

    assign p_yr = PROD_W'(r_in.red)   * PROD_W'(C_Y_R);
    assign p_yg = PROD_W'(r_in.green) * PROD_W'(C_Y_G);
    assign p_yb = PROD_W'(r_in.blue)  * PROD_W'(C_Y_B);
    assign p_ur = PROD_W'(r_in.red)   * PROD_W'(C_U_R);
    assign p_ug = PROD_W'(r_in.green) * PROD_W'(C_U_G);
    assign p_ub = PROD_W'(r_in.blue)  * PROD_W'(C_U_B);
    assign p_vr = PROD_W'(r_in.red)   * PROD_W'(C_V_R);
    assign p_vg = PROD_W'(r_in.green) * PROD_W'(C_V_G);
    assign p_vb = PROD_W'(r_in.blue)  * PROD_W'(C_V_B);

    assign y_acc = $signed({2'b00, p_yr}) + $signed({2'b00, p_yg})
                 + $signed({2'b00, p_yb});
    assign u_acc = C_OFFSET - $signed({2'b00, p_ur}) - $signed({2'b00, p_ug})
                 + $signed({2'b00, p_ub});
    assign v_acc = C_OFFSET + $signed({2'b00, p_vr}) - $signed({2'b00, p_vg})
                 - $signed({2'b00, p_vb});

    always_comb begin
        n_out.y          = sat_q16(y_acc);
        n_out.u          = sat_q16(u_acc);
        n_out.v          = sat_q16(v_acc);
        n_out.alpha      = r_in.alpha;
        n_out.line_start = r_in.line_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (s2_ready) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_pix;
        end
        if (s2_ready && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_pix   = r_out;

endmodule

// ===== rtl/byc_pair.sv =====
// ----------------------------------------------------------------------------
// byc_pair
// 4:4:4 pass-through or 4:2:2 pairing with chroma averaging, alpha gating and output register
// ----------------------------------------------------------------------------
module byc_pair (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  byc_pkg::t_cfg                    i_cfg,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  byc_pkg::t_yuv                    i_pix,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [byc_pkg::OUT_TDATA_W-1:0]  o_data
);
    import byc_pkg::*;

    logic                   r_phase;
    logic [COMP_W-1:0]      r_held_luma, r_held_u, r_held_v, r_held_alpha;
    logic                   r_valid;
    logic [OUT_TDATA_W-1:0] r_data;
    logic                   n_phase;
    logic [OUT_TDATA_W-1:0] n_data;
    logic                   accept, emit, hold;
    logic [COMP_W:0]        sum_u, sum_v;
    logic [COMP_W-1:0]      alpha_a, alpha_b;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign emit    = accept && (!i_cfg.chroma_mode || (r_phase && !i_pix.line_start));
    assign hold    = accept && !emit;

    assign sum_u = {1'b0, r_held_u} + {1'b0, i_pix.u};
    assign sum_v = {1'b0, r_held_v} + {1'b0, i_pix.v};

    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            n_phase = hold;
        end
        if (i_cfg.chroma_mode) begin
            alpha_a = i_cfg.alpha_enable ? r_held_alpha : '0;
            alpha_b = i_cfg.alpha_enable ? i_pix.alpha : '0;
            n_data  = {alpha_b, alpha_a, sum_v[COMP_W:1], sum_u[COMP_W:1],
                       i_pix.y, r_held_luma};
        end else begin
            alpha_a = i_cfg.alpha_enable ? i_pix.alpha : '0;
            alpha_b = '0;
            n_data  = {alpha_b, alpha_a, i_pix.v, i_pix.u, COMP_W'(0), i_pix.y};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (emit) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (hold) begin
            r_held_luma  <= i_pix.y;
            r_held_u     <= i_pix.u;
            r_held_v     <= i_pix.v;
            r_held_alpha <= i_pix.alpha;
        end
        if (emit) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/byc_chk.sv =====
// ----------------------------------------------------------------------------
// byc_chk
// port-level checks on the converter, bound to the top level
// ----------------------------------------------------------------------------
module byc_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_cfg_valid,
    input logic                                o_cfg_ready,
    input logic [byc_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input logic [byc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [byc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import byc_pkg::*;

    logic r_mode;
    logic r_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_alpha <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_CHROMA_MODE) begin
                r_mode <= i_cfg_data[0];
            end
            if (i_cfg_index == CFG_ALPHA_ENABLE) begin
                r_alpha <= i_cfg_data[0];
            end
        end
    end

    // stalled request holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output request changed while stalled");

    // 4:4:4 leaves the second pixel fields empty
    a_444_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !r_mode |->
            m_axis_tdata[2*COMP_W-1:COMP_W] == '0 &&
            m_axis_tdata[6*COMP_W-1:5*COMP_W] == '0)
        else $error("second pixel fields set in 4:4:4");

    // alpha gated off
    a_alpha_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !r_alpha |-> m_axis_tdata[6*COMP_W-1:4*COMP_W] == '0)
        else $error("alpha present while disabled");

    // no result without some pixel having been taken before it
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 3) ||
            $past(m_axis_tvalid && m_axis_tready) || $past(!m_axis_tready, 1) ||
            $past(!s_axis_tready, 2) || $past(!s_axis_tready, 3))
        else $error("result without a matching pixel");

endmodule

bind bgra_to_yuv_converter byc_chk u_byc_chk (.*);

// ===== bench/tb_bgra_to_yuv_converter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bgra_to_yuv_converter
// self-checking bench for the bgra to y/u/v converter: a queue-fed driver
// offers pixels, an in-bench colour matrix and pairing model predicts each
// result, and a monitor compares every output field in order. directed
// extremes and pairing corner cases come first, then random lines under
// several register settings with random stalls and one long output hold-off
// ----------------------------------------------------------------------------
module tb_bgra_to_yuv_converter;
    import byc_pkg::*;

    localparam int  CYCLE_LIMIT  = 200000;
    localparam int  DRAIN_CYCLES = 8;
    localparam int  HOLD_CYCLES  = 300;
    localparam int  GAP_PERCENT  = 7;
    localparam int  PHASE_ITEMS  = 170;
    localparam int  NUM_PHASES   = 10;
    localparam bit  MODE_444     = 1'b0;
    localparam bit  MODE_422     = 1'b1;

    localparam int  K_Y_R = 19595;
    localparam int  K_Y_G = 38470;
    localparam int  K_Y_B = 7471;
    localparam int  K_U_R = 11076;
    localparam int  K_U_G = 21692;
    localparam int  K_U_B = 32768;
    localparam int  K_V_R = 32768;
    localparam int  K_V_G = 27460;
    localparam int  K_V_B = 5308;
    localparam int  K_OFS = 128 * 65536;

    typedef struct packed {
        logic [7:0] alpha_second;
        logic [7:0] alpha_first;
        logic [7:0] chroma_v;
        logic [7:0] chroma_u;
        logic [7:0] luma_second;
        logic [7:0] luma_first;
    } t_yuv_out;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    bgra_to_yuv_converter u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    t_bgra      pix_queue [$];
    t_yuv_out   yuv_expected [$];
    t_bgra      cur_pix;
    bit         pix_taken    = 1'b0;
    int         pix_pushed   = 0;
    int         pix_accepted = 0;
    int         fail_count   = 0;
    int         cycle_count  = 0;
    bit         no_gaps      = 1'b0;
    bit         hold_trigger = 1'b0;
    bit         hold_done    = 1'b0;
    int         hold_left    = 0;

    // model state
    bit         mode_422  = MODE_444;
    bit         alpha_on  = 1'b0;
    bit         pair_odd  = 1'b0;
    logic [7:0] held_y    = '0;
    logic [7:0] held_u    = '0;
    logic [7:0] held_v    = '0;
    logic [7:0] held_a    = '0;

    string field_name [6] = '{"luma_first", "luma_second", "chroma_u", "chroma_v",
                              "alpha_first", "alpha_second"};

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [7:0] clamp_q16(input int acc);
        if (acc < 0)
            return 8'd0;
        if ((acc >>> 16) > 255)
            return 8'd255;
        return 8'(acc >>> 16);
    endfunction

    function automatic void convert_bgr(input logic [7:0] b, input logic [7:0] g,
                                        input logic [7:0] r, output logic [7:0] y,
                                        output logic [7:0] u, output logic [7:0] v);
        int bb;
        int gg;
        int rr;
        bb = b;
        gg = g;
        rr = r;
        y = clamp_q16(K_Y_R * rr + K_Y_G * gg + K_Y_B * bb);
        u = clamp_q16(K_OFS - K_U_R * rr - K_U_G * gg + K_U_B * bb);
        v = clamp_q16(K_OFS + K_V_R * rr - K_V_G * gg - K_V_B * bb);
    endfunction

    function automatic void predict_pixel(input t_bgra px);
        logic [7:0] y;
        logic [7:0] u;
        logic [7:0] v;
        logic [8:0] sum_u;
        logic [8:0] sum_v;
        t_yuv_out   res;
        convert_bgr(px.blue, px.green, px.red, y, u, v);
        res = '0;
        if (mode_422 == MODE_444) begin
            pair_odd        = 1'b0;
            res.luma_first  = y;
            res.chroma_u    = u;
            res.chroma_v    = v;
            res.alpha_first = alpha_on ? px.alpha : 8'd0;
            yuv_expected.push_back(res);
        end else if (px.line_start || !pair_odd) begin
            // even pixel, or line start restarting the pair
            held_y   = y;
            held_u   = u;
            held_v   = v;
            held_a   = px.alpha;
            pair_odd = 1'b1;
        end else begin
            sum_u            = {1'b0, held_u} + {1'b0, u};
            sum_v            = {1'b0, held_v} + {1'b0, v};
            res.luma_first   = held_y;
            res.luma_second  = y;
            res.chroma_u     = sum_u[8:1];
            res.chroma_v     = sum_v[8:1];
            res.alpha_first  = alpha_on ? held_a : 8'd0;
            res.alpha_second = alpha_on ? px.alpha : 8'd0;
            pair_odd         = 1'b0;
            yuv_expected.push_back(res);
        end
    endfunction

    function automatic logic [7:0] rand_comp();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 8'd0;
        if (pick == 1)
            return 8'd255;
        return 8'($urandom);
    endfunction

    task automatic push_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                              input logic [7:0] a, input logic ls);
        t_bgra px;
        px.blue       = b;
        px.green      = g;
        px.red        = r;
        px.alpha      = a;
        px.line_start = ls;
        pix_queue.push_back(px);
        pix_pushed++;
    endtask

    task automatic wait_drained();
        while (pix_accepted != pix_pushed || yuv_expected.size() != 0)
            @(posedge i_clk);
        // a held even pixel leaves no result, so give the pipeline time
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        if (idx == CFG_CHROMA_MODE)
            mode_422 = val[0];
        else if (idx == CFG_ALPHA_ENABLE)
            alpha_on = val[0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // pixel driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || pix_taken)) begin
            if (pix_queue.size() != 0 && (no_gaps || $urandom_range(0, 99) >= GAP_PERCENT)) begin
                cur_pix = pix_queue.pop_front();
                s_axis_tdata  <= {cur_pix.alpha, cur_pix.red, cur_pix.green, cur_pix.blue};
                s_axis_tuser  <= cur_pix.line_start;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        pix_taken = 1'b0;
    end

    // result receiver
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_trigger && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= GAP_PERCENT);
        end
    end

    // monitor and predictor
    always @(posedge i_clk) begin : monitor
        t_yuv_out   want;
        logic [OUT_TDATA_W-1:0] got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (yuv_expected.size() == 0) begin
                $error("unexpected result %h", got);
                fail_count++;
            end else begin
                want = yuv_expected.pop_front();
                for (int f = 0; f < 6; f++) begin
                    if (got[f*8 +: 8] !== want[f*8 +: 8]) begin
                        $error("%s expected %0d got %0d", field_name[f],
                               want[f*8 +: 8], got[f*8 +: 8]);
                        fail_count++;
                    end
                end
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            pix_taken = 1'b1;
            pix_accepted++;
            predict_pixel(cur_pix);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int n;
        int len;
        logic ls;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // 4:4:4 with alpha gated off after reset
        push_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        push_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        wait_drained();
        write_reg(CFG_ALPHA_ENABLE, 8'h01);
        push_pixel(8'd0, 8'd0, 8'd255, 8'hA5, 1'b0);
        push_pixel(8'd0, 8'd255, 8'd0, 8'h5A, 1'b0);
        push_pixel(8'd255, 8'd0, 8'd0, 8'd255, 1'b1);
        push_pixel(8'd255, 8'd255, 8'd0, 8'd0, 1'b0);
        push_pixel(8'd0, 8'd255, 8'd255, 8'd1, 1'b0);
        wait_drained();

        // 4:2:2 pairs, and a line start on the odd pixel dropping the held one
        write_reg(CFG_CHROMA_MODE, 8'hFF);
        push_pixel(8'd10, 8'd20, 8'd30, 8'd40, 1'b1);
        push_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
        push_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        push_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
        push_pixel(8'd1, 8'd2, 8'd3, 8'd4, 1'b1);
        push_pixel(8'd5, 8'd6, 8'd7, 8'd8, 1'b1);
        push_pixel(8'd9, 8'd10, 8'd11, 8'd12, 1'b0);

        // alpha enable changed between the two pixels of a pair
        push_pixel(8'd100, 8'd150, 8'd200, 8'd250, 1'b1);
        wait_drained();
        write_reg(CFG_ALPHA_ENABLE, 8'hFE);
        push_pixel(8'd50, 8'd60, 8'd70, 8'd80, 1'b0);

        // mode switched to 4:4:4 with an even pixel held
        push_pixel(8'd33, 8'd66, 8'd99, 8'd132, 1'b1);
        wait_drained();
        write_reg(CFG_CHROMA_MODE, 8'h80);
        write_reg(8'hFF, 8'hFF);
        write_reg(8'h02, 8'h01);
        push_pixel(8'd200, 8'd100, 8'd50, 8'd25, 1'b0);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_drained();
            write_reg(CFG_CHROMA_MODE, {7'($urandom), phase[0] ? MODE_422 : MODE_444});
            write_reg(CFG_ALPHA_ENABLE, {7'($urandom), phase[1]});
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_INDEX_W'($urandom_range(2, 255)), CFG_DATA_W'($urandom));
            no_gaps = (phase == 6);
            if (phase == 3)
                hold_trigger = 1'b1;
            n = 0;
            while (n < PHASE_ITEMS) begin
                // mostly whole pairs per line, some odd widths
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15)
                                                  : 2 * $urandom_range(1, 8);
                for (int k = 0; k < len; k++) begin
                    ls = (k == 0);
                    if ($urandom_range(0, 9) == 0)
                        ls = $urandom_range(0, 1);
                    push_pixel(rand_comp(), rand_comp(), rand_comp(), rand_comp(), ls);
                end
                n += len;
            end
        end
        wait_drained();

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/byc_pkg.sv
rtl/byc_csc.sv
rtl/byc_pair.sv
rtl/bgra_to_yuv_converter.sv
rtl/byc_chk.sv
bench/tb_bgra_to_yuv_converter.sv
